// ===== sv/lz_tbp_pkg.sv =====
`timescale 1ns / 1ps
package lz_tbp_pkg;

    localparam int ACTION_W   = 3;
    localparam int MLEN_W     = 5;
    localparam int MOFS_W     = 14;
    localparam int LCNT_W     = 5;
    localparam int BYTE_W     = 8;
    localparam int OFS_WID_W  = 4;
    localparam int LEN_WID_W  = 3;
    localparam int CNT_WID_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    typedef enum logic [ACTION_W-1:0] {
        ACT_START   = 3'd0,
        ACT_MATCH   = 3'd1,
        ACT_RUN     = 3'd2,
        ACT_LITERAL = 3'd3,
        ACT_END     = 3'd4
    } action_t;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_WIDTH  = 2'd2;

    localparam logic [OFS_WID_W-1:0] OFFSET_WIDTH_RST = 4'd11;
    localparam logic [LEN_WID_W-1:0] LENGTH_WIDTH_RST = 3'd4;
    localparam logic [CNT_WID_W-1:0] COUNT_WIDTH_RST  = 3'd3;

    typedef struct packed {
        logic [OFS_WID_W-1:0] offset_width;
        logic [LEN_WID_W-1:0] length_width;
        logic [CNT_WID_W-1:0] count_width;
    } tbp_cfg_t;

    typedef struct packed {
        logic load;
        logic is_end;
    } tbp_ctrl_t;

endpackage

// ===== sv/lz_tbp_pack.sv =====
`timescale 1ns / 1ps
module lz_tbp_pack #(
    parameter int OFFSET_MAX_BITS = 14,
    parameter int LENGTH_MAX_BITS = 4,
    parameter int COUNT_MAX_BITS  = 5,
    parameter int MAX_BITS        = 18,
    parameter int WORD_BYTES      = 4
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  lz_tbp_pkg::tbp_cfg_t                  cfg,
    input  logic                                  load,
    input  logic [lz_tbp_pkg::ACTION_W-1:0]       action,
    input  logic [lz_tbp_pkg::MLEN_W-1:0]         match_length,
    input  logic [lz_tbp_pkg::MOFS_W-1:0]         match_offset,
    input  logic [lz_tbp_pkg::LCNT_W-1:0]         literal_count,
    input  logic [lz_tbp_pkg::BYTE_W-1:0]         literal_byte,
    output logic [8*WORD_BYTES-1:0]               word,
    output logic [$clog2(WORD_BYTES+1)-1:0]       num,
    output lz_tbp_pkg::tbp_ctrl_t                 ctrl
);
    import lz_tbp_pkg::*;

    localparam int WORD_W = 8 * WORD_BYTES;
    localparam int WID_W  = $clog2(MAX_BITS + 1);
    localparam int TOT_W  = $clog2(MAX_BITS + 8);
    localparam int SH_W   = $clog2(WORD_W + 1);
    localparam int NUM_W  = $clog2(WORD_BYTES + 1);

    logic [7:0]          acc_reg;
    logic [7:0]          acc_next;
    logic [2:0]          filled_reg;
    logic [2:0]          filled_next;

    logic [WID_W-1:0]    ow;
    logic [WID_W-1:0]    lw;
    logic [WID_W-1:0]    cw;
    logic [WID_W-1:0]    w1;
    logic [WID_W-1:0]    w2;
    logic [MAX_BITS-1:0] f1;
    logic [MAX_BITS-1:0] f2;
    logic [MAX_BITS-1:0] f1_m;
    logic [MAX_BITS-1:0] f2_m;
    logic [MAX_BITS-1:0] bits;
    logic [MLEN_W-1:0]   len_m1;
    logic [TOT_W-1:0]    tot;
    logic [SH_W-1:0]     shamt;
    logic [TOT_W-4:0]    nfull;
    logic [WORD_W-1:0]   packed_word;
    logic [WORD_W-1:0]   rest_word;
    logic [WORD_W-1:0]   start_word;
    logic                is_end;
    action_t             act;

    assign ow = (32'(cfg.offset_width) > 32'(OFFSET_MAX_BITS)) ? WID_W'(OFFSET_MAX_BITS)
                                                               : WID_W'(cfg.offset_width);
    assign lw = (32'(cfg.length_width) > 32'(LENGTH_MAX_BITS)) ? WID_W'(LENGTH_MAX_BITS)
                                                               : WID_W'(cfg.length_width);
    assign cw = (32'(cfg.count_width) > 32'(COUNT_MAX_BITS)) ? WID_W'(COUNT_MAX_BITS)
                                                             : WID_W'(cfg.count_width);

    assign act    = action_t'(action);
    assign len_m1 = match_length - MLEN_W'(1);

    always_comb
    begin
        w1 = '0;
        w2 = '0;
        f1 = '0;
        f2 = '0;
        case (act)
            ACT_MATCH:
            begin
                w1 = lw;
                f1 = MAX_BITS'(len_m1);
                w2 = ow;
                f2 = MAX_BITS'(match_offset);
            end
            ACT_RUN:
            begin
                w1 = lw;
                w2 = cw;
                f2 = MAX_BITS'(literal_count);
            end
            ACT_LITERAL:
            begin
                w2 = WID_W'(BYTE_W);
                f2 = MAX_BITS'(literal_byte);
            end
            ACT_END:
            begin
                w1 = lw + cw;
            end
            default:
            begin
                w1 = '0;
            end
        endcase
    end

    assign f1_m  = f1 & ~({MAX_BITS{1'b1}} << w1);
    assign f2_m  = f2 & ~({MAX_BITS{1'b1}} << w2);
    assign bits  = (f1_m << w2) | f2_m;
    assign tot   = TOT_W'(filled_reg) + TOT_W'(w1) + TOT_W'(w2);
    assign shamt = SH_W'(WORD_W) - SH_W'(tot);
    assign nfull = tot[TOT_W-1:3];

    assign packed_word = {acc_reg, {(WORD_W-8){1'b0}}}
                       | ({{(WORD_W-MAX_BITS){1'b0}}, bits} << shamt);
    assign rest_word   = packed_word << {nfull, 3'b000};

    always_comb
    begin
        start_word = '0;
        start_word[WORD_W-1 -: 24] = {4'b0, cfg.offset_width, 5'b0, cfg.length_width,
                                      5'b0, cfg.count_width};
    end

    always_comb
    begin
        word        = packed_word;
        num         = NUM_W'(nfull);
        acc_next    = rest_word[WORD_W-1 -: 8];
        filled_next = tot[2:0];
        is_end      = 1'b0;
        case (act)
            ACT_START:
            begin
                word        = start_word;
                num         = NUM_W'(3);
                acc_next    = '0;
                filled_next = '0;
            end
            ACT_MATCH, ACT_RUN, ACT_LITERAL:
            begin
                is_end = 1'b0;
            end
            ACT_END:
            begin
                num         = NUM_W'(nfull) + NUM_W'(tot[2:0] != 3'd0);
                acc_next    = '0;
                filled_next = '0;
                is_end      = 1'b1;
            end
            default:
            begin
                num         = '0;
                acc_next    = acc_reg;
                filled_next = filled_reg;
            end
        endcase
    end

    assign ctrl.load   = load;
    assign ctrl.is_end = is_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            filled_reg <= '0;
        end
        else if (load)
        begin
            acc_reg    <= acc_next;
            filled_reg <= filled_next;
        end
    end

endmodule

// ===== sv/lz_tbp_emit.sv =====
`timescale 1ns / 1ps
module lz_tbp_emit #(
    parameter int WORD_BYTES = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lz_tbp_pkg::tbp_ctrl_t           ctrl,
    input  logic [8*WORD_BYTES-1:0]         word,
    input  logic [$clog2(WORD_BYTES+1)-1:0] num,
    output logic                            take,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [lz_tbp_pkg::BYTE_W-1:0]   packed_byte,
    output logic                            run_last,
    output logic                            stream_end
);
    import lz_tbp_pkg::*;

    localparam int WORD_W = 8 * WORD_BYTES;
    localparam int NUM_W  = $clog2(WORD_BYTES + 1);

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;
    logic [NUM_W-1:0]  cnt_reg;
    logic [NUM_W-1:0]  cnt_next;
    logic              end_reg;
    logic              end_next;
    logic              last;

    assign last        = (cnt_reg == NUM_W'(1));
    assign out_valid   = (cnt_reg != '0);
    assign take        = !out_valid || (last && out_ready);
    assign packed_byte = word_reg[WORD_W-1 -: BYTE_W];
    assign run_last    = last;
    assign stream_end  = last && end_reg;

    always_comb
    begin
        word_next = word_reg;
        cnt_next  = cnt_reg;
        end_next  = end_reg;
        if (ctrl.load)
        begin
            word_next = word;
            cnt_next  = num;
            end_next  = ctrl.is_end;
        end
        else if (out_valid && out_ready)
        begin
            word_next = word_reg << BYTE_W;
            cnt_next  = cnt_reg - NUM_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            end_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            end_reg <= end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

endmodule

// ===== sv/lz_token_bit_packer.sv =====
// The first output byte is valid in the cycle after the request is accepted.
// Throughput: one byte per cycle while out_ready is high; the next request is
// accepted in the cycle its last byte is taken. Requests yielding no byte leave the
// output idle. Config writes are always accepted, as cfg_ready is tied high.
// Reset (async, active low): bit accumulator empty, output idle, widths 11/4/3.
`timescale 1ns / 1ps
module lz_token_bit_packer #(
    parameter int OFFSET_MAX_BITS = 14,
    parameter int LENGTH_MAX_BITS = 4,
    parameter int COUNT_MAX_BITS  = 5
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lz_tbp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lz_tbp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [lz_tbp_pkg::ACTION_W-1:0]     action,
    input  logic [lz_tbp_pkg::MLEN_W-1:0]       match_length,
    input  logic [lz_tbp_pkg::MOFS_W-1:0]       match_offset,
    input  logic [lz_tbp_pkg::LCNT_W-1:0]       literal_count,
    input  logic [lz_tbp_pkg::BYTE_W-1:0]       literal_byte,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [lz_tbp_pkg::BYTE_W-1:0]       packed_byte,
    output logic                                run_last,
    output logic                                stream_end
);
    import lz_tbp_pkg::*;

    localparam int MATCH_BITS = LENGTH_MAX_BITS + OFFSET_MAX_BITS;
    localparam int RUN_BITS   = LENGTH_MAX_BITS + COUNT_MAX_BITS;
    localparam int MAX_A      = (MATCH_BITS > RUN_BITS) ? MATCH_BITS : RUN_BITS;
    localparam int MAX_BITS   = (MAX_A > BYTE_W) ? MAX_A : BYTE_W;
    localparam int WORD_BYTES = (MAX_BITS + 14) / 8;
    localparam int NUM_W      = $clog2(WORD_BYTES + 1);

    tbp_cfg_t                 cfg_reg;
    tbp_ctrl_t                ctrl;
    logic [8*WORD_BYTES-1:0]  word;
    logic [NUM_W-1:0]         num;
    logic                     take;
    logic                     in_fire;

    assign cfg_ready = 1'b1;
    assign in_ready  = take;
    assign in_fire   = in_valid && take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset_width <= OFFSET_WIDTH_RST;
            cfg_reg.length_width <= LENGTH_WIDTH_RST;
            cfg_reg.count_width  <= COUNT_WIDTH_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_OFFSET_WIDTH: cfg_reg.offset_width <= cfg_data;
                CFG_LENGTH_WIDTH: cfg_reg.length_width <= cfg_data[LEN_WID_W-1:0];
                CFG_COUNT_WIDTH:  cfg_reg.count_width  <= cfg_data[CNT_WID_W-1:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    lz_tbp_pack #(
        .OFFSET_MAX_BITS (OFFSET_MAX_BITS),
        .LENGTH_MAX_BITS (LENGTH_MAX_BITS),
        .COUNT_MAX_BITS  (COUNT_MAX_BITS),
        .MAX_BITS        (MAX_BITS),
        .WORD_BYTES      (WORD_BYTES)
    ) u_pack (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .load          (in_fire),
        .action        (action),
        .match_length  (match_length),
        .match_offset  (match_offset),
        .literal_count (literal_count),
        .literal_byte  (literal_byte),
        .word          (word),
        .num           (num),
        .ctrl          (ctrl)
    );

    lz_tbp_emit #(
        .WORD_BYTES (WORD_BYTES)
    ) u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .word        (word),
        .num         (num),
        .take        (take),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .packed_byte (packed_byte),
        .run_last    (run_last),
        .stream_end  (stream_end)
    );

endmodule

// ===== sv/lz_tbp_checker.sv =====
`timescale 1ns / 1ps
module lz_tbp_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [lz_tbp_pkg::BYTE_W-1:0]     packed_byte,
    input logic                              run_last,
    input logic                              stream_end
);
    import lz_tbp_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(packed_byte)
                                    && $stable(run_last) && $stable(stream_end))
        else $error("output request changed while stalled");

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with output empty");

    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stream_end |-> run_last)
        else $error("stream end without run last");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !run_last |-> !in_ready)
        else $error("input taken while burst pending");

endmodule

bind lz_token_bit_packer lz_tbp_checker u_chk (.*);
